FILE: rtl/stbt_pkg.sv
// ----------------------------------------------------------------------------
// stbt_pkg
// Types, sizes and codes shared by the sorted time bracket table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stbt_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TIME_W      = 24;
  localparam int unsigned REC_W       = 20;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned ENTRY_W     = TIME_W + REC_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_EXACT    = 3'd2,
    ST_BRACKET  = 3'd3,
    ST_NO_UPPER = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT,
    S_INS_WR,
    S_UP_CHK,
    S_LO_CHK,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    rd_mid;
    logic    srch_upd;
    logic    shift_init;
    logic    shift_step;
    logic    write_new;
    logic    rd_pos;
    logic    rd_pos_m1;
    logic    set_status;
    status_e status;
    logic    set_exact;
    logic    set_upper;
    logic    set_lower;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic srch_done;
    logic shift_done;
    logic pos_lt_count;
    logic pos_zero;
    logic hit_eq;
    logic up_far;
    logic lo_far;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/stbt_ctrl.sv
// ----------------------------------------------------------------------------
// stbt_ctrl
// Sequencer for insert and query: binary search, shift, neighbor checks.
// ----------------------------------------------------------------------------
`default_nettype none

module stbt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           op_i,
  input  wire logic           out_ready_i,
  input  wire stbt_pkg::sts_t sts_i,
  output stbt_pkg::cmd_t      cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);

  stbt_pkg::state_e state_q, state_d;
  logic             op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbt_pkg::S_IDLE;
      op_q    <= stbt_pkg::OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cmd_o       = '0;
    cmd_o.status = stbt_pkg::ST_INSERTED;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      stbt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = op_i;
          if (op_i == stbt_pkg::OP_INSERT && sts_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = stbt_pkg::ST_FULL;
            state_d          = stbt_pkg::S_RESP;
          end else begin
            state_d = stbt_pkg::S_SRCH_RD;
          end
        end
      end

      stbt_pkg::S_SRCH_RD: begin
        if (!sts_i.srch_done) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = stbt_pkg::S_SRCH_CMP;
        end else if (op_q == stbt_pkg::OP_INSERT) begin
          cmd_o.shift_init = 1'b1;
          state_d          = stbt_pkg::S_SHIFT;
        end else if (sts_i.pos_lt_count) begin
          cmd_o.rd_pos = 1'b1;
          state_d      = stbt_pkg::S_UP_CHK;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = stbt_pkg::ST_NO_UPPER;
          state_d          = stbt_pkg::S_RESP;
        end
      end

      stbt_pkg::S_SRCH_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = stbt_pkg::S_SRCH_RD;
      end

      stbt_pkg::S_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = stbt_pkg::S_INS_WR;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end

      stbt_pkg::S_INS_WR: begin
        cmd_o.write_new  = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = stbt_pkg::ST_INSERTED;
        state_d          = stbt_pkg::S_RESP;
      end

      stbt_pkg::S_UP_CHK: begin
        cmd_o.set_status = 1'b1;
        state_d          = stbt_pkg::S_RESP;
        if (sts_i.hit_eq) begin
          cmd_o.status    = stbt_pkg::ST_EXACT;
          cmd_o.set_exact = 1'b1;
        end else if (sts_i.up_far) begin
          cmd_o.status = stbt_pkg::ST_NO_UPPER;
        end else begin
          cmd_o.status    = stbt_pkg::ST_BRACKET;
          cmd_o.set_upper = 1'b1;
          // fetch the earlier neighbor unless at the start of the table
          if (!sts_i.pos_zero) begin
            cmd_o.rd_pos_m1 = 1'b1;
            state_d         = stbt_pkg::S_LO_CHK;
          end
        end
      end

      stbt_pkg::S_LO_CHK: begin
        cmd_o.set_lower = !sts_i.lo_far;
        state_d         = stbt_pkg::S_RESP;
      end

      stbt_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = stbt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = stbt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/stbt_dp.sv
// ----------------------------------------------------------------------------
// stbt_dp
// Entry memory, search bounds, shift pointer, gap compares, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbt_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire stbt_pkg::cmd_t                cmd_i,
  output stbt_pkg::sts_t                     sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [stbt_pkg::TIME_W-1:0]   cfg_wdata_i,
  input  wire logic                          op_i,
  input  wire logic [stbt_pkg::TIME_W-1:0]   time_key_i,
  input  wire logic [stbt_pkg::REC_W-1:0]    record_index_i,
  output logic [stbt_pkg::STATUS_W-1:0]      status_o,
  output logic                               found_o,
  output logic                               lower_valid_o,
  output logic [stbt_pkg::TIME_W-1:0]        lower_time_o,
  output logic [stbt_pkg::REC_W-1:0]         lower_index_o,
  output logic                               upper_valid_o,
  output logic [stbt_pkg::TIME_W-1:0]        upper_time_o,
  output logic [stbt_pkg::REC_W-1:0]         upper_index_o
);

  localparam int unsigned IDX_W  = stbt_pkg::IDX_W;
  localparam int unsigned CNT_W  = stbt_pkg::CNT_W;
  localparam int unsigned TIME_W = stbt_pkg::TIME_W;
  localparam int unsigned REC_W  = stbt_pkg::REC_W;

  logic [stbt_pkg::ENTRY_W-1:0] entry_mem [stbt_pkg::TABLE_DEPTH];
  logic [stbt_pkg::ENTRY_W-1:0] rd_q;

  logic [CNT_W-1:0]  count_q;
  logic [TIME_W-1:0] max_gap_q;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_addr_q;
  logic [CNT_W-1:0]  src_q;

  logic              op_q;
  logic [TIME_W-1:0] key_q;
  logic [REC_W-1:0]  rec_q;
  logic [CNT_W-1:0]  lo_q, hi_q;

  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  src_m1;
  logic [TIME_W-1:0] rd_time;
  logic [REC_W-1:0]  rd_rec;
  logic              go_right;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  logic [stbt_pkg::ENTRY_W-1:0] mem_wd;

  assign rd_time = rd_q[stbt_pkg::ENTRY_W-1:REC_W];
  assign rd_rec  = rd_q[REC_W-1:0];
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign src_m1  = src_q - CNT_W'(1);

  // insert keeps equal keys ahead of the new entry
  assign go_right = (op_q == stbt_pkg::OP_INSERT) ? (rd_time <= key_q) : (rd_time < key_q);

  assign sts_o.full         = (count_q == CNT_W'(stbt_pkg::TABLE_DEPTH));
  assign sts_o.srch_done    = (lo_q == hi_q);
  assign sts_o.shift_done   = (src_q == lo_q) && !pend_q;
  assign sts_o.pos_lt_count = (lo_q < count_q);
  assign sts_o.pos_zero     = (lo_q == '0);
  assign sts_o.hit_eq       = (rd_time == key_q);
  assign sts_o.up_far       = ((rd_time - key_q) > max_gap_q);
  assign sts_o.lo_far       = ((key_q - rd_time) > max_gap_q);

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = lo_q[IDX_W-1:0];
    mem_wd = {key_q, rec_q};
    mem_re = 1'b0;
    mem_ra = mid[IDX_W-1:0];
    if (cmd_i.shift_step && pend_q) begin
      mem_we = 1'b1;
      mem_wa = pend_addr_q + IDX_W'(1);
      mem_wd = rd_q;
    end
    if (cmd_i.write_new) begin
      mem_we = 1'b1;
    end
    if (cmd_i.rd_mid) begin
      mem_re = 1'b1;
    end
    if (cmd_i.rd_pos) begin
      mem_re = 1'b1;
      mem_ra = lo_q[IDX_W-1:0];
    end
    if (cmd_i.rd_pos_m1) begin
      mem_re = 1'b1;
      mem_ra = lo_q[IDX_W-1:0] - IDX_W'(1);
    end
    if (cmd_i.shift_step && (src_q != lo_q)) begin
      mem_re = 1'b1;
      mem_ra = src_m1[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= entry_mem[mem_ra];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      max_gap_q   <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      src_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        max_gap_q <= cfg_wdata_i;
      end
      if (cmd_i.write_new) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.shift_init) begin
        src_q  <= count_q;
        pend_q <= 1'b0;
      end
      if (cmd_i.shift_step) begin
        // walk down from the top, one entry read and one written per cycle
        if (src_q != lo_q) begin
          pend_q      <= 1'b1;
          pend_addr_q <= src_m1[IDX_W-1:0];
          src_q       <= src_m1;
        end else begin
          pend_q <= 1'b0;
        end
      end
    end
  end

  // item, search bounds and result; every path sets the status before the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q          <= op_i;
      key_q         <= time_key_i;
      rec_q         <= record_index_i;
      lo_q          <= '0;
      hi_q          <= count_q;
      found_o       <= 1'b0;
      lower_valid_o <= 1'b0;
      lower_time_o  <= '0;
      lower_index_o <= '0;
      upper_valid_o <= 1'b0;
      upper_time_o  <= '0;
      upper_index_o <= '0;
    end
    if (cmd_i.srch_upd) begin
      if (go_right) begin
        lo_q <= mid + CNT_W'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.set_status) begin
      status_o <= cmd_i.status;
    end
    if (cmd_i.set_exact) begin
      found_o       <= 1'b1;
      lower_valid_o <= 1'b1;
      lower_time_o  <= key_q;
      lower_index_o <= rd_rec;
    end
    if (cmd_i.set_upper) begin
      upper_valid_o <= 1'b1;
      upper_time_o  <= rd_time;
      upper_index_o <= rd_rec;
    end
    if (cmd_i.set_lower) begin
      found_o       <= 1'b1;
      lower_valid_o <= 1'b1;
      lower_time_o  <= rd_time;
      lower_index_o <= rd_rec;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_time_bracket_table.sv
// ----------------------------------------------------------------------------
// sorted_time_bracket_table
// Time-sorted table of (time, record index) with insert and bracket query.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries op_i, time_key_i and
// record_index_i; one transfer gives exactly one result on the output
// channel (out_valid_o/out_ready_i). The block works on one item at a time:
// in_ready_o is high only in idle, from the cycle after the result transfer.
// With n entries stored and pos the slot found, each item first runs a
// binary search of at most ceil(log2(n+1)) steps; each step reads the middle
// entry, then compares. An insert then moves the n - pos entries from pos up
// one per cycle and writes the new entry; an insert into a full table gives
// ST_FULL without a search. A query checks pos and, for a bracket, pos - 1.
// The result is held in an output register until the receiver takes it; a
// stalled receiver stalls the next input transfer. The user writes max_gap by
// cfg_we_i / cfg_wdata_i while idle, which the block does not enforce. Reset
// empties the table and clears max_gap; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_time_bracket_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [stbt_pkg::TIME_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [stbt_pkg::TIME_W-1:0]   time_key_i,
  input  wire logic [stbt_pkg::REC_W-1:0]    record_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [stbt_pkg::STATUS_W-1:0]      status_o,
  output logic                               found_o,
  output logic                               lower_valid_o,
  output logic [stbt_pkg::TIME_W-1:0]        lower_time_o,
  output logic [stbt_pkg::REC_W-1:0]         lower_index_o,
  output logic                               upper_valid_o,
  output logic [stbt_pkg::TIME_W-1:0]        upper_time_o,
  output logic [stbt_pkg::REC_W-1:0]         upper_index_o
);

  stbt_pkg::cmd_t cmd;
  stbt_pkg::sts_t sts;

  stbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  stbt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .time_key_i     (time_key_i),
    .record_index_i (record_index_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .lower_valid_o  (lower_valid_o),
    .lower_time_o   (lower_time_o),
    .lower_index_o  (lower_index_o),
    .upper_valid_o  (upper_valid_o),
    .upper_time_o   (upper_time_o),
    .upper_index_o  (upper_index_o)
  );

endmodule

`default_nettype wire
